@@ src/abspi_pkg.sv @@
// ----------------------------------------------------------------------------
// abspi_pkg
// Shared types and codes of the altitude-banded speed interpolator.
// ----------------------------------------------------------------------------
package abspi_pkg;

   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_SPEED    = 2'd1;
   localparam logic [1:0] REQ_THROTTLE = 2'd2;

   localparam int DEADBAND = 32;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         level_index;
      logic [15:0]        altitude;
      logic [23:0]        std_value;
      logic [23:0]        min_value;
      logic signed [15:0] throttle;
      logic [23:0]        speed;
   } abspi_req_type;

   typedef struct packed {
      logic [23:0]        speed_out;
      logic signed [15:0] throttle_out;
      logic               status;
   } abspi_rsp_type;

   typedef struct packed {
      logic [15:0] alt;
      logic [23:0] std_spd;
      logic [23:0] min_spd;
   } abspi_entry_type;

endpackage

@@ src/altitude_banded_speed_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// altitude_banded_speed_interpolator_core
// Breakpoint table in a RAM, serial search and interpolation, throttle map.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | abspi_req_type
//   rsp     | out       | rsp_valid/rsp_stall | abspi_rsp_type
//   csr     | in        | APB                 | levels_in_use at 0x0
//
// Loads and unknown items: result in the cycle after acceptance. Queries:
// a read and a check per level searched; when interpolating, a multiply and
// a divide each for standard and minimum speed; then a throttle scaling for a
// speed query, a divide or nothing for a throttle query; result registered.
// Synchronous reset; table contents are undefined until loaded.
// A stalled result holds; no new item is taken while it waits.
// ----------------------------------------------------------------------------
module altitude_banded_speed_interpolator_core #(
   parameter int LEVELS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  abspi_pkg::abspi_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output abspi_pkg::abspi_rsp_type rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import abspi_pkg::*;

   localparam int AW = $clog2(LEVELS);
   localparam int NW = $clog2(LEVELS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CHK, S_MUL, S_DIV, S_DWAIT, S_ADJ, S_FIN, S_IWAIT, S_OUT
   } state_type;

   state_type              state_ff;
   logic [4:0]             levels_ff;
   logic [NW-1:0]          nlev;
   logic [NW-1:0]          idx_ff;
   abspi_req_type          item_ff;
   abspi_entry_type        lo_ff, hi_ff, rd_entry;
   logic                   sel_min_ff;
   logic signed [41:0]     prod_ff;
   logic                   neg_ff;
   logic                   up_ff;
   logic signed [25:0]     sd_ff, mn_ff;
   logic [47:0]            div_num_ff;
   logic [24:0]            div_den_ff;
   logic                   div_start_ff;
   logic                   div_done;
   logic [23:0]            div_quo;
   logic [23:0]            spd_ff;
   logic signed [15:0]     th_ff;
   logic                   st_ff;
   abspi_rsp_type          rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free, req_accept;
   logic                   wr_en;
   logic [63:0]            rd_raw;

   logic signed [24:0]     diff;
   logic [15:0]            dz, da;
   logic [41:0]            prod_mag;
   logic signed [25:0]     off, interp_val, dsm;
   logic signed [41:0]     adj;
   logic signed [27:0]     r_val, mx, vs;
   logic [25:0]            mag;

   always_comb begin
      if (levels_ff == 5'd0) begin
         nlev = NW'(1);
      end else if (int'(levels_ff) > LEVELS) begin
         nlev = NW'(LEVELS);
      end else begin
         nlev = NW'(levels_ff);
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(state_ff == S_IDLE && out_free);
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && req_data.req_type == REQ_LOAD
                       && int'(req_data.level_index) < LEVELS;
   assign rd_entry   = abspi_entry_type'(rd_raw);

   always_comb begin
      if ((req_accept && req_data.req_type != REQ_SPEED
           && req_data.req_type != REQ_THROTTLE)
          || (state_ff == S_OUT && out_free)) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   abspi_ram #(.WIDTH(64), .DEPTH(LEVELS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.level_index)),
      .wr_data ({req_data.altitude, req_data.std_value, req_data.min_value}),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   abspi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      diff = sel_min_ff ? ($signed({1'b0, hi_ff.min_spd}) - $signed({1'b0, lo_ff.min_spd}))
                        : ($signed({1'b0, hi_ff.std_spd}) - $signed({1'b0, lo_ff.std_spd}));
      dz   = item_ff.altitude - lo_ff.alt;
      da   = hi_ff.alt - lo_ff.alt;
      prod_mag = prod_ff[41] ? 42'(-prod_ff) : 42'(prod_ff);
      off  = neg_ff ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
      interp_val = (sel_min_ff ? $signed({2'b0, lo_ff.min_spd})
                               : $signed({2'b0, lo_ff.std_spd})) + off;
      dsm  = sd_ff - mn_ff;
      adj  = prod_ff + (prod_ff[41] ? 42'sd32767 : 42'sd0);
      r_val = 28'(sd_ff) + 28'(adj >>> 15);
      mx   = 28'(sd_ff) + 28'(sd_ff) - 28'(mn_ff);
      vs   = $signed({4'b0, item_ff.speed});
      mag  = (vs > 28'(sd_ff)) ? 26'(vs - 28'(sd_ff)) : 26'(28'(sd_ff) - vs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         levels_ff    <= 5'd1;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         idx_ff       <= '0;
         sel_min_ff   <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
            levels_ff <= csr_pwdata[4:0];
         end
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  item_ff <= req_data;
                  spd_ff  <= '0;
                  th_ff   <= '0;
                  st_ff   <= 1'b0;
                  idx_ff  <= '0;
                  if (req_data.req_type == REQ_SPEED || req_data.req_type == REQ_THROTTLE) begin
                     state_ff <= S_RD;
                  end else begin
                     rsp_ff <= '0;
                  end
               end
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               if (item_ff.altitude < rd_entry.alt) begin
                  if (idx_ff == '0) begin
                     sd_ff    <= $signed({2'b0, rd_entry.std_spd});
                     mn_ff    <= $signed({2'b0, rd_entry.min_spd});
                     state_ff <= S_ADJ;
                  end else begin
                     hi_ff      <= rd_entry;
                     sel_min_ff <= 1'b0;
                     state_ff   <= S_MUL;
                  end
               end else begin
                  lo_ff <= rd_entry;
                  if (idx_ff + NW'(1) >= nlev) begin
                     sd_ff    <= $signed({2'b0, rd_entry.std_spd});
                     mn_ff    <= $signed({2'b0, rd_entry.min_spd});
                     state_ff <= S_ADJ;
                  end else begin
                     idx_ff   <= idx_ff + NW'(1);
                     state_ff <= S_RD;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= diff * $signed({1'b0, dz});
               state_ff <= S_DIV;
            end
            S_DIV: begin
               neg_ff       <= prod_ff[41];
               div_num_ff   <= {6'b0, prod_mag};
               div_den_ff   <= {9'b0, da};
               div_start_ff <= 1'b1;
               state_ff     <= S_DWAIT;
            end
            S_DWAIT: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  if (!sel_min_ff) begin
                     sd_ff      <= interp_val;
                     sel_min_ff <= 1'b1;
                     state_ff   <= S_MUL;
                  end else begin
                     mn_ff    <= interp_val;
                     state_ff <= S_ADJ;
                  end
               end
            end
            S_ADJ: begin
               if (item_ff.req_type == REQ_SPEED) begin
                  prod_ff  <= item_ff.throttle * dsm;
                  state_ff <= S_FIN;
               end else if (vs < 28'(mn_ff) || vs > mx) begin
                  st_ff    <= 1'b1;
                  state_ff <= S_OUT;
               end else if (sd_ff[23:8] == item_ff.speed[23:8]) begin
                  state_ff <= S_OUT;
               end else begin
                  up_ff        <= vs > 28'(sd_ff);
                  div_num_ff   <= {8'b0, mag[24:0], 15'b0};
                  div_den_ff   <= dsm[24:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= S_IWAIT;
               end
            end
            S_FIN: begin
               if (item_ff.throttle <= 16'(DEADBAND) && item_ff.throttle >= -16'(DEADBAND)) begin
                  spd_ff <= sd_ff[23:0];
               end else if (r_val < 0) begin
                  spd_ff <= '0;
               end else if (r_val > 28'sh0FFFFFF) begin
                  spd_ff <= 24'hFFFFFF;
               end else begin
                  spd_ff <= r_val[23:0];
               end
               state_ff <= S_OUT;
            end
            S_IWAIT: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  if (up_ff) begin
                     th_ff <= (div_quo > 24'd32767) ? 16'sh7FFF : $signed(div_quo[15:0]);
                  end else begin
                     th_ff <= (div_quo >= 24'd32768) ? 16'sh8000 : -$signed(div_quo[15:0]);
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_ff   <= '{speed_out: spd_ff, throttle_out: th_ff, status: st_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_prdata = {27'b0, levels_ff};
   assign csr_pready = 1'b1;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && rsp_valid_ff && rsp_stall))
      else $error("item taken while result stalled");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DWAIT || state_ff == S_IWAIT))
      else $error("divider done outside wait");
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHK |-> idx_ff < nlev)
      else $error("search index past level count");
endmodule

@@ src/abspi_ram.sv @@
// ----------------------------------------------------------------------------
// abspi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module abspi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/abspi_div.sv @@
// ----------------------------------------------------------------------------
// abspi_div
// Restoring divider, one quotient bit per cycle, 24-bit quotient.
// The upper 24 bits of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module abspi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] num,
   input  logic [24:0] den,
   output logic        done,
   output logic [23:0] quo
);
   logic [25:0] rem_ff;
   logic [23:0] sh_ff;
   logic [23:0] quo_ff;
   logic [24:0] den_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [25:0] trial_in;
   logic        fit_in;

   always_comb begin
      trial_in = {rem_ff[24:0], sh_ff[23]};
      fit_in   = trial_in >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= {2'b0, num[47:24]};
            sh_ff   <= num[23:0];
            den_ff  <= den;
            quo_ff  <= '0;
            cnt_ff  <= 5'd24;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fit_in ? (trial_in - {1'b0, den_ff}) : trial_in;
            sh_ff  <= {sh_ff[22:0], 1'b0};
            quo_ff <= {quo_ff[22:0], fit_in};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

@@ sim/tb_altitude_banded_speed_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// tb_altitude_banded_speed_interpolator_core
// Drives load, speed, throttle and unknown items with random bursts and stalls and
// checks every result against a predictor of the interpolated speed table.
// ----------------------------------------------------------------------------
module tb_altitude_banded_speed_interpolator_core;
   import abspi_pkg::*;

   localparam int NLEV = 16;
   localparam logic [2:0] ADDR_LEVELS = 3'd0;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   abspi_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   abspi_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   altitude_banded_speed_interpolator_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [15:0] tbl_alt [NLEV];
   logic [23:0] tbl_std [NLEV];
   logic [23:0] tbl_min [NLEV];
   int levels_setting = 1;

   abspi_req_type pending_items[$];
   abspi_rsp_type expected_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit long_hold_done = 1'b0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int used_levels();
      if (levels_setting < 1) return 1;
      if (levels_setting > NLEV) return NLEV;
      return levels_setting;
   endfunction

   function automatic longint interp(input bit pick_min, input logic [15:0] z);
      int n, i;
      longint lo, hi, alo, ahi;
      n = used_levels();
      i = 0;
      while (i < n && !(z < tbl_alt[i])) i++;
      if (i == 0) return pick_min ? tbl_min[0] : tbl_std[0];
      if (i >= n) return pick_min ? tbl_min[n-1] : tbl_std[n-1];
      lo = pick_min ? tbl_min[i-1] : tbl_std[i-1];
      hi = pick_min ? tbl_min[i] : tbl_std[i];
      alo = tbl_alt[i-1];
      ahi = tbl_alt[i];
      if (ahi <= alo) return lo;
      return lo + ((hi - lo) * (longint'(z) - alo)) / (ahi - alo);
   endfunction

   function automatic abspi_rsp_type predict_speed_table(input abspi_req_type it);
      abspi_rsp_type r;
      longint sd, mn, mx, v, spd, den, mag, q;
      longint t;
      bit up;
      r = '0;
      t = it.throttle;
      case (it.req_type)
         REQ_LOAD: begin
            tbl_alt[it.level_index] = it.altitude;
            tbl_std[it.level_index] = it.std_value;
            tbl_min[it.level_index] = it.min_value;
         end
         REQ_SPEED: begin
            sd = interp(1'b0, it.altitude);
            mn = interp(1'b1, it.altitude);
            spd = sd;
            if (t > DEADBAND || t < -DEADBAND) spd = sd + (t * (sd - mn)) / 32768;
            if (spd < 0) spd = 0;
            if (spd > 24'hFFFFFF) spd = 24'hFFFFFF;
            r.speed_out = spd[23:0];
         end
         REQ_THROTTLE: begin
            sd = interp(1'b0, it.altitude);
            mn = interp(1'b1, it.altitude);
            mx = 2 * sd - mn;
            v = it.speed;
            if (v < mn || v > mx) r.status = 1'b1;
            else if ((sd >>> 8) != (v >>> 8)) begin
               up = v > sd;
               den = up ? mx - sd : sd - mn;
               mag = up ? v - sd : sd - v;
               if (den > 0) begin
                  q = (mag * 32768) / den;
                  if (up) begin
                     if (q > 32767) q = 32767;
                     r.throttle_out = q[15:0];
                  end else begin
                     if (q > 32768) q = 32768;
                     r.throttle_out = 16'(-q);
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(predict_speed_table(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
               end
            end else req_valid <= 1'b0;
         end
      end
   end

   // monitor
   abspi_rsp_type want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.speed_out !== want.speed_out)
                  report("speed_out", rsp_data.speed_out, want.speed_out);
               if (rsp_data.throttle_out !== want.throttle_out)
                  report("throttle_out", rsp_data.throttle_out, want.throttle_out);
               if (rsp_data.status !== want.status)
                  report("status", rsp_data.status, want.status);
            end
         end
         if (hold_rsp) rsp_stall <= 1'b1;
         else case ($urandom_range(0, 3))
            0: rsp_stall <= 1'b1;
            default: rsp_stall <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // long hold-off once, while the sender keeps offering
   initial begin
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL altitude_banded_speed_interpolator_core");
         $finish;
      end
   end

   task automatic csr_write(input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_LEVELS;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      levels_setting = value[4:0];
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_rsp.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic abspi_req_type rand_fields();
      abspi_req_type it;
      it.req_type = 2'($urandom_range(0, 3));
      it.level_index = 4'($urandom);
      it.altitude = 16'($urandom);
      it.std_value = 24'($urandom);
      it.min_value = 24'($urandom);
      it.throttle = 16'($urandom);
      it.speed = 24'($urandom);
      return it;
   endfunction

   // non-descending table with sane or random speeds
   task automatic queue_table(input int n, input bit sane);
      abspi_req_type it;
      int a, step;
      a = $urandom_range(0, 2000);
      for (int i = 0; i < n; i++) begin
         it = rand_fields();
         it.req_type = REQ_LOAD;
         it.level_index = 4'(i);
         it.altitude = 16'(a);
         if (sane) begin
            it.std_value = 24'($urandom_range(4096, 24'hFFFFFF / 2));
            it.min_value = 24'($urandom_range(0, it.std_value));
         end
         pending_items.push_back(it);
         step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4000);
         a = (a + step > 65535) ? 65535 : a + step;
      end
   endtask

   function automatic abspi_req_type rand_query();
      abspi_req_type it;
      it = rand_fields();
      it.req_type = $urandom_range(0, 1) ? REQ_SPEED : REQ_THROTTLE;
      if ($urandom_range(0, 3) == 0) it.throttle = 16'($urandom_range(0, 80) - 40);
      return it;
   endfunction

   abspi_req_type d;
   int phase_lv;
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: every table slot, extremes and deadband
      queue_table(NLEV, 1'b1);
      d = '0; d.req_type = REQ_LOAD; d.level_index = 4'd15; d.altitude = 16'hFFFF;
      d.std_value = 24'hFFFFFF; d.min_value = 24'h0;
      pending_items.push_back(d);
      drain();
      csr_write(32'd16);
      d = '0; d.req_type = REQ_SPEED; d.throttle = 16'sh7FFF; d.altitude = 16'hFFFF;
      pending_items.push_back(d);
      d.throttle = 16'sh8000; pending_items.push_back(d);
      d.throttle = 16'sd32; pending_items.push_back(d);
      d.throttle = -16'sd33; pending_items.push_back(d);
      d.altitude = 16'h0; d.throttle = 16'sd33; pending_items.push_back(d);
      d = '0; d.req_type = REQ_THROTTLE; d.altitude = 16'hFFFF; d.speed = 24'hFFFFFF;
      pending_items.push_back(d);
      d.speed = 24'h0; pending_items.push_back(d);
      d.speed = 24'h7FFFFF; pending_items.push_back(d);
      d = rand_fields(); d.req_type = REQ_UNKNOWN; pending_items.push_back(d);
      d = '0; d.req_type = REQ_LOAD; d.level_index = 4'd0; d.altitude = 16'd100;
      d.std_value = 24'd1000; d.min_value = 24'd2000;  // min above std
      pending_items.push_back(d);
      d = '0; d.req_type = REQ_THROTTLE; d.speed = 24'd1500; pending_items.push_back(d);
      drain();
      csr_write(32'd0);
      d = '0; d.req_type = REQ_SPEED; d.altitude = 16'd5000; d.throttle = 16'sd100;
      pending_items.push_back(d);
      drain();
      csr_write(32'd31);
      for (int k = 0; k < 8; k++) pending_items.push_back(rand_query());
      drain();
      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         phase_lv = (ph % 4 == 0) ? NLEV : $urandom_range(1, NLEV);
         queue_table(NLEV, $urandom_range(0, 4) != 0);
         drain();
         csr_write(ph == 5 ? 32'd1 : 32'(phase_lv) | ($urandom_range(0, 1) << 5));
         for (int k = 0; k < 130; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               d = rand_fields();
               if (d.req_type != REQ_LOAD) d.req_type = REQ_UNKNOWN;
               pending_items.push_back(d);
            end else pending_items.push_back(rand_query());
         end
         drain();
      end
      if (errors == 0) $display("PASS altitude_banded_speed_interpolator_core");
      else $display("FAIL altitude_banded_speed_interpolator_core");
      $finish;
   end

endmodule

@@ files.f @@
src/abspi_pkg.sv
src/abspi_ram.sv
src/abspi_div.sv
src/altitude_banded_speed_interpolator_core.sv
sim/tb_altitude_banded_speed_interpolator_core.sv
